// ----- src/pns_pkg.sv -----
`default_nettype none

package pns_pkg;

    localparam int SOUGHT_ENTRIES = 4;
    localparam int HW_ENTRIES     = 4;
    localparam int LIST_N         = (SOUGHT_ENTRIES < HW_ENTRIES) ? SOUGHT_ENTRIES : HW_ENTRIES;
    localparam int PRIO_W         = (LIST_N > 1) ? $clog2(LIST_N) : 1;

    localparam int COORD_W   = 16;
    localparam int ID_W      = 16;
    localparam int CLASS_W   = 8;
    localparam int COUNT_W   = 3;
    localparam int RANGE_W   = 16;
    localparam int SQ_W      = 2 * COORD_W;
    localparam int DIST_W    = SQ_W + 1;
    localparam int RSQ_W     = 2 * RANGE_W;
    localparam int CLASSES_W = HW_ENTRIES * CLASS_W;
    localparam int RANGES_W  = HW_ENTRIES * RANGE_W;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 64;

    localparam int S_DATA_W = 56;
    localparam int M_DATA_W = 48;

    localparam logic [RANGE_W-1:0] RANGE_UNLIMITED = '1;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_SCANNER_X      = 3'd0,
        REG_SCANNER_Y      = 3'd1,
        REG_SCANNER_ID     = 3'd2,
        REG_SOUGHT_COUNT   = 3'd3,
        REG_SOUGHT_CLASSES = 3'd4,
        REG_RANGE_TABLE    = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [ID_W-1:0]           id;
        logic [COUNT_W-1:0]        count;
        logic [CLASSES_W-1:0]      classes;
        logic [RANGES_W-1:0]       ranges;
    } pns_cfg_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [CLASS_W-1:0]        cls;
        logic [ID_W-1:0]           id;
        logic                      last;
    } pns_cand_t;

    typedef struct packed {
        logic                      last;
        logic                      hit;
        logic [PRIO_W-1:0]         prio;
        logic [DIST_W-1:0]         dist_sq;
        logic [RSQ_W-1:0]          range_sq;
        logic                      unlimited;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [ID_W-1:0]           id;
    } pns_eval_t;

endpackage

`default_nettype wire

// ----- src/priority_nearest_target_select.sv -----
// Picks one target per scan: candidates stream in one beat per clock, and the
// beat with tlast closes the scan and yields one result beat. A candidate counts
// when its id differs from the scanner, its class is among the first sought_count
// list entries and its squared distance lies within that entry's squared range
// (range 65535 means unlimited). Earlier list entries win, then the nearer
// candidate, and on a tie the later one. The block takes a new candidate every
// cycle; while a result waits on the output, candidates keep flowing until the
// next closing beat reaches the best-candidate stage, where it holds the input
// until the waiting result is taken. A closing beat passes the input register,
// then the match and square stage, then the best-candidate stage with the output
// register, before its result is presented. Write configuration only while no
// scan is in flight.

`default_nettype none

module priority_nearest_target_select
    import pns_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // cand_x, cand_y, cand_class, cand_id
    input  wire logic [S_DATA_W-1:0]   s_tdata,
    input  wire logic                  s_tlast,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // target_x, target_y, target_id
    output logic [M_DATA_W-1:0]        m_tdata,
    // found
    output logic                       m_tuser
);

    pns_cfg_t  cfg_reg;
    pns_cfg_t  cfg_next;

    logic      s0_valid_reg;
    logic      s0_valid_next;
    pns_cand_t s0_cand_reg;
    pns_cand_t s0_cand_next;

    logic      match_ready;
    logic      eval_valid;
    logic      best_ready;
    pns_eval_t eval;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_SCANNER_X:      cfg_next.x       = cfg_wdata[COORD_W-1:0];
                REG_SCANNER_Y:      cfg_next.y       = cfg_wdata[COORD_W-1:0];
                REG_SCANNER_ID:     cfg_next.id      = cfg_wdata[ID_W-1:0];
                REG_SOUGHT_COUNT:   cfg_next.count   = cfg_wdata[COUNT_W-1:0];
                REG_SOUGHT_CLASSES: cfg_next.classes = cfg_wdata[CLASSES_W-1:0];
                REG_RANGE_TABLE:    cfg_next.ranges  = cfg_wdata[RANGES_W-1:0];
                default:            cfg_next         = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.x       <= '0;
            cfg_reg.y       <= '0;
            cfg_reg.id      <= '0;
            cfg_reg.count   <= '0;
            cfg_reg.classes <= '0;
            cfg_reg.ranges  <= '1;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        s0_cand_next.x    = s_tdata[15:0];
        s0_cand_next.y    = s_tdata[31:16];
        s0_cand_next.cls  = s_tdata[39:32];
        s0_cand_next.id   = s_tdata[55:40];
        s0_cand_next.last = s_tlast;
    end

    assign s_tready = !s0_valid_reg || match_ready;

    always_comb begin
        s0_valid_next = s0_valid_reg;
        if (s_tready) begin
            s0_valid_next = s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_valid_reg <= 1'b0;
        end else begin
            s0_valid_reg <= s0_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            s0_cand_reg <= s0_cand_next;
        end
    end

    pns_match u_match (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s0_valid_reg),
        .in_ready  (match_ready),
        .in_cand   (s0_cand_reg),
        .out_valid (eval_valid),
        .out_ready (best_ready),
        .out_eval  (eval)
    );

    pns_best u_best (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (eval_valid),
        .in_ready (best_ready),
        .in_eval  (eval),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_found  (m_tuser),
        .m_data   (m_tdata)
    );

endmodule

`default_nettype wire

// ----- src/pns_match.sv -----
`default_nettype none

module pns_match
    import pns_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire pns_cfg_t  cfg,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire pns_cand_t in_cand,
    output logic           out_valid,
    input  wire logic      out_ready,
    output pns_eval_t      out_eval
);

    logic      valid_reg;
    logic      valid_next;
    pns_eval_t eval_reg;
    pns_eval_t eval_next;

    logic                      hit;
    logic [PRIO_W-1:0]         prio;
    logic [RANGE_W-1:0]        rng;
    logic signed [COORD_W:0]   dx;
    logic signed [COORD_W:0]   dy;
    logic signed [COORD_W:0]   ndx;
    logic signed [COORD_W:0]   ndy;
    logic [COORD_W-1:0]        adx;
    logic [COORD_W-1:0]        ady;
    logic [SQ_W-1:0]           sqx;
    logic [SQ_W-1:0]           sqy;

    // The loop runs from the lowest priority upward so that the earliest entry wins.
    always_comb begin
        hit  = 1'b0;
        prio = '0;
        rng  = '0;
        for (int i = LIST_N - 1; i >= 0; i--) begin
            if ((COUNT_W'(i) < cfg.count) &&
                (cfg.classes[CLASS_W*i +: CLASS_W] == in_cand.cls)) begin
                hit  = 1'b1;
                prio = PRIO_W'(i);
                rng  = cfg.ranges[RANGE_W*i +: RANGE_W];
            end
        end
        hit = hit && (in_cand.id != cfg.id);
    end

    always_comb begin
        dx  = {in_cand.x[COORD_W-1], in_cand.x} - {cfg.x[COORD_W-1], cfg.x};
        dy  = {in_cand.y[COORD_W-1], in_cand.y} - {cfg.y[COORD_W-1], cfg.y};
        ndx = -dx;
        ndy = -dy;
        adx = dx[COORD_W] ? ndx[COORD_W-1:0] : dx[COORD_W-1:0];
        ady = dy[COORD_W] ? ndy[COORD_W-1:0] : dy[COORD_W-1:0];
        sqx = adx * adx;
        sqy = ady * ady;
    end

    always_comb begin
        eval_next.last      = in_cand.last;
        eval_next.hit       = hit;
        eval_next.prio      = prio;
        eval_next.dist_sq   = {1'b0, sqx} + {1'b0, sqy};
        eval_next.range_sq  = rng * rng;
        eval_next.unlimited = (rng == RANGE_UNLIMITED);
        eval_next.x         = in_cand.x;
        eval_next.y         = in_cand.y;
        eval_next.id        = in_cand.id;
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_eval  = eval_reg;

    always_comb begin
        valid_next = valid_reg;
        if (in_ready) begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            eval_reg <= eval_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/pns_best.sv -----
`default_nettype none

module pns_best
    import pns_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire pns_eval_t in_eval,
    output logic           m_tvalid,
    input  wire logic      m_tready,
    output logic           m_found,
    output logic [M_DATA_W-1:0] m_data
);

    logic                      best_valid_reg;
    logic                      best_valid_next;
    logic [PRIO_W-1:0]         best_prio_reg;
    logic [DIST_W-1:0]         best_dist_reg;
    logic signed [COORD_W-1:0] best_x_reg;
    logic signed [COORD_W-1:0] best_y_reg;
    logic [ID_W-1:0]           best_id_reg;

    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic                      out_found_reg;
    logic [M_DATA_W-1:0]       out_data_reg;
    logic [M_DATA_W-1:0]       out_data_next;

    logic                      consume;
    logic                      in_range;
    logic                      better;
    logic                      take;
    logic                      new_valid;
    logic signed [COORD_W-1:0] new_x;
    logic signed [COORD_W-1:0] new_y;
    logic [ID_W-1:0]           new_id;

    // Only a closing beat needs room in the output register.
    assign in_ready = !in_eval.last || !out_valid_reg || m_tready;
    assign consume  = in_valid && in_ready;

    always_comb begin
        in_range  = in_eval.unlimited || (in_eval.dist_sq <= {1'b0, in_eval.range_sq});
        better    = !best_valid_reg || (in_eval.prio < best_prio_reg) ||
                    ((in_eval.prio == best_prio_reg) && (in_eval.dist_sq <= best_dist_reg));
        take      = in_eval.hit && in_range && better;
        new_valid = best_valid_reg || take;
        new_x     = take ? in_eval.x  : best_x_reg;
        new_y     = take ? in_eval.y  : best_y_reg;
        new_id    = take ? in_eval.id : best_id_reg;
    end

    always_comb begin
        best_valid_next = best_valid_reg;
        if (consume) begin
            best_valid_next = in_eval.last ? 1'b0 : new_valid;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg && !m_tready;
        if (consume && in_eval.last) begin
            out_valid_next = 1'b1;
        end
        out_data_next = new_valid ? {new_id, new_y, new_x} : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            best_valid_reg <= best_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (consume && take && !in_eval.last) begin
            best_prio_reg <= in_eval.prio;
            best_dist_reg <= in_eval.dist_sq;
            best_x_reg    <= in_eval.x;
            best_y_reg    <= in_eval.y;
            best_id_reg   <= in_eval.id;
        end
        if (consume && in_eval.last) begin
            out_found_reg <= new_valid;
            out_data_reg  <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_found  = out_found_reg;
    assign m_data   = out_data_reg;

endmodule

`default_nettype wire

// ----- src/pns_checker.sv -----
`default_nettype none

module pns_checker
    import pns_pkg::*;
(
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_tvalid,
    input wire logic                s_tready,
    input wire logic                s_tlast,
    input wire logic                m_tvalid,
    input wire logic                m_tready,
    input wire logic [M_DATA_W-1:0] m_tdata,
    input wire logic                m_tuser
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("result without a target carries nonzero data");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result beat right after reset");

    a_result_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast, 3))
        else $error("result beat without a closing input beat");

endmodule

bind priority_nearest_target_select pns_checker u_pns_checker (.*);

`default_nettype wire

// ----- bench/priority_nearest_target_select_tb.sv -----
`timescale 1ns / 1ps

module priority_nearest_target_select_tb;
    import pns_pkg::*;

    localparam int HOLD_CYCLES = 400;
    localparam int PHASE_BEATS = 100;

    typedef struct {
        bit          found;
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] id;
    } scan_result_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_we = 1'b0;
    cfg_reg_t              cfg_addr = REG_SCANNER_X;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata = '0;
    logic                  s_tlast = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tuser;

    pns_cand_t    cand_queue[$];
    scan_result_t pending_targets[$];
    pns_cfg_t     scan_setup;
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;
    bit           s_taken = 1'b0;
    bit           holding = 1'b0;
    int           mismatches = 0;
    event         hold_kick;

    bit          best_on;
    int unsigned best_rank;
    longint      best_dsq;
    logic [15:0] best_x;
    logic [15:0] best_y;
    logic [15:0] best_id;

    priority_nearest_target_select u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    task automatic flag_mismatch(input string msg);
        if (mismatches < 40) begin
            $display("ERROR at %0t: %s", $realtime, msg);
        end
        mismatches++;
    endtask

    // Tracks the best candidate of the open scan and closes it on the last beat.
    task automatic score_candidate(input pns_cand_t c);
        int unsigned n;
        bit          hit;
        int unsigned rank;
        logic [15:0] reach;
        longint      dx;
        longint      dy;
        longint      dsq;
        bit          take;
        scan_result_t res;
        n = scan_setup.count;
        if (n > LIST_N) begin
            n = LIST_N;
        end
        hit = 1'b0;
        rank = 0;
        reach = '0;
        if (c.id != scan_setup.id) begin
            for (int i = 0; i < n; i++) begin
                if (!hit && scan_setup.classes[8*i +: 8] == c.cls) begin
                    hit = 1'b1;
                    rank = i;
                    reach = scan_setup.ranges[16*i +: 16];
                end
            end
        end
        if (hit) begin
            dx = longint'($signed(c.x)) - longint'($signed(scan_setup.x));
            dy = longint'($signed(c.y)) - longint'($signed(scan_setup.y));
            dsq = dx * dx + dy * dy;
            if (reach == RANGE_UNLIMITED || dsq <= longint'(reach) * longint'(reach)) begin
                take = !best_on || rank < best_rank || (rank == best_rank && dsq <= best_dsq);
                if (take) begin
                    best_on = 1'b1;
                    best_rank = rank;
                    best_dsq = dsq;
                    best_x = c.x;
                    best_y = c.y;
                    best_id = c.id;
                end
            end
        end
        if (c.last) begin
            res.found = best_on;
            res.x = best_on ? best_x : 16'd0;
            res.y = best_on ? best_y : 16'd0;
            res.id = best_on ? best_id : 16'd0;
            pending_targets.push_back(res);
            best_on = 1'b0;
            best_rank = 0;
            best_dsq = 0;
            best_x = '0;
            best_y = '0;
            best_id = '0;
        end
    endtask

    task automatic check_target();
        scan_result_t want;
        if (pending_targets.size() == 0) begin
            flag_mismatch("result beat with no scan pending");
        end else begin
            want = pending_targets.pop_front();
            if (m_tuser !== want.found) begin
                flag_mismatch($sformatf("found %b, expected %b", m_tuser, want.found));
            end
            if (m_tdata[15:0] !== want.x) begin
                flag_mismatch($sformatf("target_x %h, expected %h", m_tdata[15:0], want.x));
            end
            if (m_tdata[31:16] !== want.y) begin
                flag_mismatch($sformatf("target_y %h, expected %h", m_tdata[31:16], want.y));
            end
            if (m_tdata[47:32] !== want.id) begin
                flag_mismatch($sformatf("target_id %h, expected %h", m_tdata[47:32], want.id));
            end
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                check_target();
            end
            if (s_tvalid && s_tready) begin
                score_candidate('{x: s_tdata[15:0], y: s_tdata[31:16], cls: s_tdata[39:32],
                                  id: s_tdata[55:40], last: s_tlast});
                s_taken = 1'b1;
            end
        end
    end

    always @(negedge aclk) begin
        pns_cand_t next_beat;
        if (aresetn && !(s_tvalid && !s_taken)) begin
            if (cand_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                next_beat = cand_queue.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= {next_beat.id, next_beat.cls, next_beat.y, next_beat.x};
                s_tlast <= next_beat.last;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        s_taken = 1'b0;
    end

    always @(negedge aclk) begin
        m_tready <= !holding && ($urandom_range(99) >= recv_stall_pct);
    end

    initial begin
        forever begin
            @(hold_kick);
            holding = 1'b1;
            repeat (HOLD_CYCLES) @(posedge aclk);
            holding = 1'b0;
        end
    end

    task automatic write_reg(input cfg_reg_t which, input logic [63:0] value);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= which;
        cfg_wdata <= value;
        case (which)
            REG_SCANNER_X:      scan_setup.x = value[15:0];
            REG_SCANNER_Y:      scan_setup.y = value[15:0];
            REG_SCANNER_ID:     scan_setup.id = value[15:0];
            REG_SOUGHT_COUNT:   scan_setup.count = value[2:0];
            REG_SOUGHT_CLASSES: scan_setup.classes = value[31:0];
            REG_RANGE_TABLE:    scan_setup.ranges = value;
            default: ;
        endcase
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic add_beat(input int x, input int y, input int cls, input int id, input bit last);
        cand_queue.push_back('{x: 16'(x), y: 16'(y), cls: 8'(cls), id: 16'(id), last: last});
    endtask

    task automatic wait_idle();
        wait (cand_queue.size() == 0 && !s_tvalid);
        wait (pending_targets.size() == 0);
        repeat (8) @(posedge aclk);
    endtask

    task automatic random_setup();
        logic [31:0] classes;
        logic [63:0] reaches;
        for (int i = 0; i < 4; i++) begin
            classes[8*i +: 8] = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(7));
            case ($urandom_range(3))
                0:       reaches[16*i +: 16] = RANGE_UNLIMITED;
                1:       reaches[16*i +: 16] = 16'($urandom_range(400));
                2:       reaches[16*i +: 16] = 16'($urandom);
                default: reaches[16*i +: 16] = 16'($urandom_range(20));
            endcase
        end
        write_reg(REG_SCANNER_X, 64'($urandom_range(65535)));
        write_reg(REG_SCANNER_Y, 64'($urandom_range(65535)));
        write_reg(REG_SCANNER_ID, 64'($urandom_range(65535)));
        write_reg(REG_SOUGHT_COUNT, 64'($urandom_range(7)));
        write_reg(REG_SOUGHT_CLASSES, 64'(classes));
        write_reg(REG_RANGE_TABLE, reaches);
    endtask

    task automatic queue_scan(input int len);
        pns_cand_t c;
        int        slot;
        for (int k = 0; k < len; k++) begin
            slot = $urandom_range(3);
            c.cls = ($urandom_range(9) < 7) ? scan_setup.classes[8*slot +: 8] : 8'($urandom);
            c.id = ($urandom_range(6) == 0) ? scan_setup.id : 16'($urandom);
            if ($urandom_range(9) < 6) begin
                c.x = scan_setup.x + 16'($urandom_range(1000) - 500);
                c.y = scan_setup.y + 16'($urandom_range(1000) - 500);
            end else begin
                c.x = 16'($urandom);
                c.y = 16'($urandom);
            end
            c.last = (k == len - 1);
            cand_queue.push_back(c);
        end
    endtask

    initial begin
        int made;
        int len;
        scan_setup = '{x: '0, y: '0, id: '0, count: '0, classes: '0, ranges: '1};
        best_on = 1'b0;
        best_rank = 0;
        best_dsq = 0;
        best_x = '0;
        best_y = '0;
        best_id = '0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // After reset the sought list is empty, so nothing qualifies.
        add_beat(0, 0, 8'h00, 1, 1'b0);
        add_beat(5, 5, 8'h00, 0, 1'b1);
        wait_idle();

        // Entry 2 repeats the class of entry 0 with a wider range that must not apply.
        write_reg(REG_SCANNER_X, 64'd0);
        write_reg(REG_SCANNER_Y, 64'd0);
        write_reg(REG_SCANNER_ID, 64'd5);
        write_reg(REG_SOUGHT_COUNT, 64'd4);
        write_reg(REG_SOUGHT_CLASSES, 64'hFF10_2010);
        write_reg(REG_RANGE_TABLE, 64'h0000_01F4_FFFF_0064);
        add_beat(32767, -32768, 8'h20, 1, 1'b0);
        add_beat(60, 80, 8'h10, 2, 1'b1);
        add_beat(72, 96, 8'h10, 3, 1'b0);
        add_beat(-32768, -32768, 8'h20, 65535, 1'b1);
        add_beat(3, 4, 8'h20, 7, 1'b0);
        add_beat(-4, 3, 8'h20, 8, 1'b1);
        add_beat(0, 0, 8'hFF, 9, 1'b0);
        add_beat(0, 0, 8'h10, 5, 1'b1);
        add_beat(1, 1, 8'h00, 0, 1'b0);
        add_beat(2, 2, 8'h33, 10, 1'b1);
        add_beat(100, 100, 8'h20, 11, 1'b0);
        add_beat(10, 10, 8'h20, 12, 1'b0);
        add_beat(200, 0, 8'h20, 13, 1'b1);
        add_beat(0, 90, 8'h10, 15, 1'b0);
        add_beat(1, 0, 8'h20, 14, 1'b1);
        wait_idle();

        // Count above the list size, scanner in a corner, zero and unlimited ranges.
        write_reg(REG_SCANNER_X, 64'h8000);
        write_reg(REG_SCANNER_Y, 64'h7FFF);
        write_reg(REG_SCANNER_ID, 64'hFFFF);
        write_reg(REG_SOUGHT_COUNT, 64'd7);
        write_reg(REG_SOUGHT_CLASSES, 64'h00FF_00FF);
        write_reg(REG_RANGE_TABLE, 64'hFFFF_0000_FFFF_0000);
        add_beat(-32768, 32767, 8'h00, 1, 1'b0);
        add_beat(32767, -32768, 8'hFF, 2, 1'b0);
        add_beat(0, 0, 8'hFF, 65535, 1'b1);
        add_beat(32767, -32768, 8'hFF, 3, 1'b1);
        wait_idle();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
                3: begin send_idle_pct = 6;  recv_stall_pct = 6;  end
                5: begin send_idle_pct = 60; recv_stall_pct = 60; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            random_setup();
            if (ph == 4) begin
                -> hold_kick;
            end
            made = 0;
            while (made < PHASE_BEATS) begin
                if (ph == 4) begin
                    len = $urandom_range(1, 2);
                end else if ($urandom_range(9) == 0) begin
                    len = $urandom_range(10, 24);
                end else begin
                    len = $urandom_range(1, 6);
                end
                queue_scan(len);
                made += len;
            end
            wait_idle();
        end

        repeat (20) @(posedge aclk);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #1000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
